### hdl/knnmc_pkg.sv
// ----------------------------------------------------------------------------
// knnmc_pkg
// Types and constants shared by the k-nearest-neighbour classifier modules.
// ----------------------------------------------------------------------------
package knnmc_pkg;

	localparam int COORD_BITS = 16;
	localparam int LABEL_BITS = 8;
	localparam int DIFF_BITS  = COORD_BITS + 1;
	localparam int PROD_BITS  = 2 * DIFF_BITS;
	localparam int SQ_BITS    = 2 * COORD_BITS;
	localparam int DIST_BITS  = SQ_BITS + 1;
	localparam int VOTE_BITS  = 5;
	localparam int ADDR_BITS  = 4;
	localparam int DATA_BITS  = 32;

	localparam logic [1:0] REG_QUERY_X         = 2'd0;
	localparam logic [1:0] REG_QUERY_Y         = 2'd1;
	localparam logic [1:0] REG_NEIGHBOUR_COUNT = 2'd2;

	typedef enum logic [1:0] {
		ST_FILL,
		ST_COUNT,
		ST_SCAN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic                  valid;
		logic                  last;
		logic [LABEL_BITS-1:0] label;
		logic [DIST_BITS-1:0]  sq_dist;
	} dist_item_t;

	typedef struct packed {
		logic                  ins;
		logic [LABEL_BITS-1:0] label;
		logic [DIST_BITS-1:0]  sq_dist;
	} ins_bus_t;

	typedef struct packed {
		logic                  clr;
		logic                  cnt_en;
		logic [LABEL_BITS-1:0] label;
	} vote_bus_t;

endpackage

### hdl/knnmc_dist.sv
// ----------------------------------------------------------------------------
// knnmc_dist
// Two-stage squared Euclidean distance pipeline: differences, then squares.
// ----------------------------------------------------------------------------
module knnmc_dist (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  accept,
	input  logic signed [knnmc_pkg::COORD_BITS-1:0] point_x,
	input  logic signed [knnmc_pkg::COORD_BITS-1:0] point_y,
	input  logic [knnmc_pkg::LABEL_BITS-1:0]      point_label,
	input  logic                                  last_point,
	input  logic signed [knnmc_pkg::COORD_BITS-1:0] query_x,
	input  logic signed [knnmc_pkg::COORD_BITS-1:0] query_y,
	output knnmc_pkg::dist_item_t                 item,
	output logic                                  last_pending
);

	logic                                   v_s1, v_s2;
	logic                                   last_s1, last_s2;
	logic [knnmc_pkg::LABEL_BITS-1:0]       label_s1, label_s2;
	logic signed [knnmc_pkg::DIFF_BITS-1:0] dx_s1, dy_s1;
	logic signed [knnmc_pkg::PROD_BITS-1:0] prod_x, prod_y;
	logic [knnmc_pkg::SQ_BITS-1:0]          sqx_s2, sqy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1    <= knnmc_pkg::DIFF_BITS'(point_x) - knnmc_pkg::DIFF_BITS'(query_x);
		dy_s1    <= knnmc_pkg::DIFF_BITS'(point_y) - knnmc_pkg::DIFF_BITS'(query_y);
		label_s1 <= point_label;
		last_s1  <= last_point;
		sqx_s2   <= prod_x[knnmc_pkg::SQ_BITS-1:0];
		sqy_s2   <= prod_y[knnmc_pkg::SQ_BITS-1:0];
		label_s2 <= label_s1;
		last_s2  <= last_s1;
	end

	assign prod_x = dx_s1 * dx_s1;
	assign prod_y = dy_s1 * dy_s1;

	always_comb begin
		item.valid   = v_s2;
		item.last    = last_s2;
		item.label   = label_s2;
		item.sq_dist = knnmc_pkg::DIST_BITS'(sqx_s2) + knnmc_pkg::DIST_BITS'(sqy_s2);
	end

	assign last_pending = (v_s1 && last_s1) || (v_s2 && last_s2);

endmodule

### hdl/knnmc_cell.sv
// ----------------------------------------------------------------------------
// knnmc_cell
// One slot of the sorted neighbour list: keeps, takes the new point or takes
// its lower neighbor's entry; counts matching labels during the vote.
// ----------------------------------------------------------------------------
module knnmc_cell (
	input  logic                             clk,
	input  knnmc_pkg::ins_bus_t              ins,
	input  knnmc_pkg::vote_bus_t             vote,
	input  logic                             occupied,
	input  logic                             voter,
	input  logic                             prev_le,
	input  logic [knnmc_pkg::DIST_BITS-1:0]  prev_dist,
	input  logic [knnmc_pkg::LABEL_BITS-1:0] prev_label,
	output logic                             le,
	output logic [knnmc_pkg::DIST_BITS-1:0]  sq_dist,
	output logic [knnmc_pkg::LABEL_BITS-1:0] label,
	output logic [knnmc_pkg::VOTE_BITS-1:0]  count
);

	logic [knnmc_pkg::DIST_BITS-1:0]  dist_q;
	logic [knnmc_pkg::LABEL_BITS-1:0] label_q;
	logic [knnmc_pkg::VOTE_BITS-1:0]  count_q;

	assign le = occupied && (dist_q <= ins.sq_dist);

	always_ff @(posedge clk) begin
		if (ins.ins && !le) begin
			if (prev_le) begin
				dist_q  <= ins.sq_dist;
				label_q <= ins.label;
			end else begin
				dist_q  <= prev_dist;
				label_q <= prev_label;
			end
		end
		if (vote.clr) begin
			count_q <= '0;
		end else if (vote.cnt_en && voter && (label_q == vote.label)) begin
			count_q <= count_q + knnmc_pkg::VOTE_BITS'(1);
		end
	end

	assign sq_dist = dist_q;
	assign label   = label_q;
	assign count   = count_q;

endmodule

### hdl/knnmc_ctrl.sv
// ----------------------------------------------------------------------------
// knnmc_ctrl
// Fill count, vote sequencing over the cell row and majority scan.
// ----------------------------------------------------------------------------
module knnmc_ctrl #(
	parameter int MAX_NEIGHBOURS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  knnmc_pkg::dist_item_t                 item,
	input  logic                                  last_pending,
	input  logic [knnmc_pkg::VOTE_BITS-1:0]       k_cfg,
	input  logic [knnmc_pkg::LABEL_BITS-1:0]      cell_label [MAX_NEIGHBOURS],
	input  logic [knnmc_pkg::VOTE_BITS-1:0]       cell_count [MAX_NEIGHBOURS],
	input  logic                                  out_ready,
	output logic [MAX_NEIGHBOURS-1:0]             occupied,
	output logic [MAX_NEIGHBOURS-1:0]             voter,
	output knnmc_pkg::vote_bus_t                  vote,
	output logic                                  in_ready,
	output logic                                  out_valid,
	output logic [knnmc_pkg::LABEL_BITS-1:0]      winning_label,
	output logic [knnmc_pkg::VOTE_BITS-1:0]       vote_count
);

	localparam int CNT_W = $clog2(MAX_NEIGHBOURS + 1);
	localparam int IDX_W = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;
	localparam int CW    = (CNT_W > knnmc_pkg::VOTE_BITS) ? CNT_W : knnmc_pkg::VOTE_BITS;

	knnmc_pkg::state_t                 state_q, state_d;
	logic [CNT_W-1:0]                  filled_q, fill_after;
	logic [CNT_W-1:0]                  n_q;
	logic [IDX_W-1:0]                  idx_q;
	logic [knnmc_pkg::LABEL_BITS-1:0]  best_label_q;
	logic [knnmc_pkg::VOTE_BITS-1:0]   best_cnt_q;
	logic [CW-1:0]                     k_ext, k_eff, n_new;
	logic                              idx_last;
	logic                              finish;
	logic [knnmc_pkg::LABEL_BITS-1:0]  sel_label;
	logic [knnmc_pkg::VOTE_BITS-1:0]   sel_count;
	logic                              better;

	assign finish     = item.valid && item.last;
	assign fill_after = (filled_q < CNT_W'(MAX_NEIGHBOURS)) ? filled_q + CNT_W'(1) : filled_q;
	assign k_ext      = CW'(k_cfg);
	assign k_eff      = (k_ext == '0) ? CW'(1) :
	                    ((k_ext > CW'(MAX_NEIGHBOURS)) ? CW'(MAX_NEIGHBOURS) : k_ext);
	assign n_new      = (CW'(fill_after) < k_eff) ? CW'(fill_after) : k_eff;
	assign idx_last   = (CNT_W'(idx_q) == n_q - CNT_W'(1));
	assign sel_label  = cell_label[idx_q];
	assign sel_count  = cell_count[idx_q];
	assign better     = (sel_count > best_cnt_q) ||
	                    ((sel_count == best_cnt_q) && (sel_label < best_label_q));

	always_comb begin
		state_d = state_q;
		case (state_q)
			knnmc_pkg::ST_FILL: begin
				if (finish) state_d = knnmc_pkg::ST_COUNT;
			end
			knnmc_pkg::ST_COUNT: begin
				if (idx_last) state_d = knnmc_pkg::ST_SCAN;
			end
			knnmc_pkg::ST_SCAN: begin
				if (idx_last) state_d = knnmc_pkg::ST_OUT;
			end
			knnmc_pkg::ST_OUT: begin
				if (out_ready) state_d = knnmc_pkg::ST_FILL;
			end
			default: state_d = knnmc_pkg::ST_FILL;
		endcase
	end

	always_comb begin
		in_ready     = (state_q == knnmc_pkg::ST_FILL) && !last_pending && !item.valid ||
		               (state_q == knnmc_pkg::ST_FILL) && !last_pending && !item.last;
		out_valid    = (state_q == knnmc_pkg::ST_OUT);
		vote.clr     = finish;
		vote.cnt_en  = (state_q == knnmc_pkg::ST_COUNT);
		vote.label   = sel_label;
		winning_label = best_label_q;
		vote_count    = best_cnt_q;
	end

	always_comb begin
		for (int i = 0; i < MAX_NEIGHBOURS; i++) begin
			occupied[i] = (CNT_W'(i) < filled_q);
			voter[i]    = (CNT_W'(i) < n_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= knnmc_pkg::ST_FILL;
			filled_q <= '0;
			n_q      <= CNT_W'(1);
			idx_q    <= '0;
		end else begin
			state_q <= state_d;
			if (item.valid) begin
				filled_q <= item.last ? '0 : fill_after;
			end
			if (finish) begin
				n_q   <= CNT_W'(n_new);
				idx_q <= '0;
			end else if (state_q == knnmc_pkg::ST_COUNT || state_q == knnmc_pkg::ST_SCAN) begin
				idx_q <= idx_last ? '0 : idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == knnmc_pkg::ST_COUNT && idx_last) begin
			best_cnt_q   <= '0;
			best_label_q <= '0;
		end else if (state_q == knnmc_pkg::ST_SCAN && better) begin
			best_cnt_q   <= sel_count;
			best_label_q <= sel_label;
		end
	end

	a_item_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid |-> (state_q == knnmc_pkg::ST_FILL))
		else $error("point reached the cell row outside the fill phase");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == knnmc_pkg::ST_COUNT || state_q == knnmc_pkg::ST_SCAN)
		|-> (CNT_W'(idx_q) < n_q))
		else $error("vote index beyond voter count");

	a_winner_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == knnmc_pkg::ST_OUT) |-> (best_cnt_q != '0))
		else $error("result presented with zero votes");

	a_list_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> (filled_q == '0) && (n_q != '0))
		else $error("list not cleared after last point");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != knnmc_pkg::ST_FILL) |-> !in_ready)
		else $error("input ready while voting");

endmodule

### hdl/knn_majority_classifier_core.sv
// ----------------------------------------------------------------------------
// knn_majority_classifier_core
// k-nearest-neighbour majority classifier over a stream of labelled points.
// ----------------------------------------------------------------------------
// Training points are taken one per cycle while a set streams in; each passes
// a two-stage distance pipeline and is inserted into a row of MAX_NEIGHBOURS
// cells that keep the nearest points sorted. After the point marked last is
// accepted, input ready stays low until the result transaction completes:
// first the distance pipeline, then a count phase in which the cell row counts
// label matches over n cells and a scan phase that searches the counts for the
// winner, where n = min(k, points held), and then the wait on the output side.
// The vote sequencer visits one cell per cycle in both phases.
// ----------------------------------------------------------------------------
module knn_majority_classifier_core #(
	parameter int MAX_NEIGHBOURS = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    psel,
	input  logic                                    penable,
	input  logic                                    pwrite,
	input  logic [knnmc_pkg::ADDR_BITS-1:0]         paddr,
	input  logic [knnmc_pkg::DATA_BITS-1:0]         pwdata,
	output logic [knnmc_pkg::DATA_BITS-1:0]         prdata,
	output logic                                    pready,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic signed [knnmc_pkg::COORD_BITS-1:0] point_x,
	input  logic signed [knnmc_pkg::COORD_BITS-1:0] point_y,
	input  logic [knnmc_pkg::LABEL_BITS-1:0]        point_label,
	input  logic                                    last_point,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [knnmc_pkg::LABEL_BITS-1:0]        winning_label,
	output logic [knnmc_pkg::VOTE_BITS-1:0]         vote_count
);

	logic signed [knnmc_pkg::COORD_BITS-1:0] query_x_q, query_y_q;
	logic [knnmc_pkg::VOTE_BITS-1:0]         k_q;
	logic                                    cfg_wr;
	knnmc_pkg::dist_item_t                   item;
	knnmc_pkg::ins_bus_t                     ins;
	knnmc_pkg::vote_bus_t                    vote;
	logic                                    last_pending;
	logic [MAX_NEIGHBOURS-1:0]               occupied, voter;
	logic                                    cell_le    [MAX_NEIGHBOURS];
	logic [knnmc_pkg::DIST_BITS-1:0]         cell_dist  [MAX_NEIGHBOURS];
	logic [knnmc_pkg::LABEL_BITS-1:0]        cell_label [MAX_NEIGHBOURS];
	logic [knnmc_pkg::VOTE_BITS-1:0]         cell_count [MAX_NEIGHBOURS];

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_x_q <= '0;
			query_y_q <= '0;
			k_q       <= knnmc_pkg::VOTE_BITS'(1);
		end else if (cfg_wr) begin
			case (paddr[3:2])
				knnmc_pkg::REG_QUERY_X:         query_x_q <= pwdata[knnmc_pkg::COORD_BITS-1:0];
				knnmc_pkg::REG_QUERY_Y:         query_y_q <= pwdata[knnmc_pkg::COORD_BITS-1:0];
				knnmc_pkg::REG_NEIGHBOUR_COUNT: k_q <= pwdata[knnmc_pkg::VOTE_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			knnmc_pkg::REG_QUERY_X:         prdata = knnmc_pkg::DATA_BITS'(query_x_q);
			knnmc_pkg::REG_QUERY_Y:         prdata = knnmc_pkg::DATA_BITS'(query_y_q);
			knnmc_pkg::REG_NEIGHBOUR_COUNT: prdata = knnmc_pkg::DATA_BITS'(k_q);
			default:                        prdata = '0;
		endcase
	end

	knnmc_dist u_dist (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (in_valid && in_ready),
		.point_x      (point_x),
		.point_y      (point_y),
		.point_label  (point_label),
		.last_point   (last_point),
		.query_x      (query_x_q),
		.query_y      (query_y_q),
		.item         (item),
		.last_pending (last_pending)
	);

	always_comb begin
		ins.ins     = item.valid;
		ins.label   = item.label;
		ins.sq_dist = item.sq_dist;
	end

	for (genvar i = 0; i < MAX_NEIGHBOURS; i++) begin : g_cell
		if (i == 0) begin : g_head
			knnmc_cell u_cell (
				.clk        (clk),
				.ins        (ins),
				.vote       (vote),
				.occupied   (occupied[i]),
				.voter      (voter[i]),
				.prev_le    (1'b1),
				.prev_dist  (item.sq_dist),
				.prev_label (item.label),
				.le         (cell_le[i]),
				.sq_dist    (cell_dist[i]),
				.label      (cell_label[i]),
				.count      (cell_count[i])
			);
		end else begin : g_body
			knnmc_cell u_cell (
				.clk        (clk),
				.ins        (ins),
				.vote       (vote),
				.occupied   (occupied[i]),
				.voter      (voter[i]),
				.prev_le    (cell_le[i-1]),
				.prev_dist  (cell_dist[i-1]),
				.prev_label (cell_label[i-1]),
				.le         (cell_le[i]),
				.sq_dist    (cell_dist[i]),
				.label      (cell_label[i]),
				.count      (cell_count[i])
			);
		end
	end

	knnmc_ctrl #(
		.MAX_NEIGHBOURS (MAX_NEIGHBOURS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.item          (item),
		.last_pending  (last_pending),
		.k_cfg         (k_q),
		.cell_label    (cell_label),
		.cell_count    (cell_count),
		.out_ready     (out_ready),
		.occupied      (occupied),
		.voter         (voter),
		.vote          (vote),
		.in_ready      (in_ready),
		.out_valid     (out_valid),
		.winning_label (winning_label),
		.vote_count    (vote_count)
	);

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the k-nearest-neighbour majority classifier core.
// Streams training sets against programmed query points and values of k,
// tracks the sorted list of nearest points in a scoreboard, and compares
// every vote result field by field. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------

typedef logic signed [knnmc_pkg::COORD_BITS-1:0] coord_t;
typedef logic [knnmc_pkg::LABEL_BITS-1:0]        label_t;
typedef logic [knnmc_pkg::VOTE_BITS-1:0]         count_t;
typedef logic [knnmc_pkg::DIST_BITS-1:0]         dist_t;

typedef struct {
	label_t label;
	count_t count;
} vote_t;

class knn_scoreboard #(int DEPTH = 16);
	coord_t query_x;
	coord_t query_y;
	count_t k_reg;
	dist_t  near_dist [DEPTH];
	label_t near_label[DEPTH];
	int     held;
	vote_t  expected_votes[$];
	int     errors;
	int     votes_checked;

	function new();
		query_x       = '0;
		query_y       = '0;
		k_reg         = count_t'(1);
		held          = 0;
		errors        = 0;
		votes_checked = 0;
	endfunction

	function void write_reg(logic [1:0] idx, logic [31:0] value);
		case (idx)
			knnmc_pkg::REG_QUERY_X: begin
				query_x = value[knnmc_pkg::COORD_BITS-1:0];
			end
			knnmc_pkg::REG_QUERY_Y: begin
				query_y = value[knnmc_pkg::COORD_BITS-1:0];
			end
			knnmc_pkg::REG_NEIGHBOUR_COUNT: begin
				k_reg = value[knnmc_pkg::VOTE_BITS-1:0];
			end
			default: begin
			end
		endcase
	endfunction

	function dist_t distance_to_query(coord_t x, coord_t y);
		longint dx;
		longint dy;
		dist_t  d;
		dx = longint'(x) - longint'(query_x);
		dy = longint'(y) - longint'(query_y);
		d  = dist_t'(dx * dx + dy * dy);
		return d;
	endfunction

	function void insert_nearest(dist_t d, label_t label);
		int pos;
		int i;
		pos = 0;
		while (pos < held && near_dist[pos] <= d)
			pos++;
		if (pos >= DEPTH)
			return;
		i = (held < DEPTH) ? held : DEPTH - 1;
		while (i > pos) begin
			near_dist[i]  = near_dist[i-1];
			near_label[i] = near_label[i-1];
			i--;
		end
		near_dist[pos]  = d;
		near_label[pos] = label;
		if (held < DEPTH)
			held++;
	endfunction

	function void note_point(coord_t x, coord_t y, label_t label, logic last);
		int    k;
		int    n;
		int    c;
		vote_t v;
		insert_nearest(distance_to_query(x, y), label);
		if (!last)
			return;
		k = k_reg;
		if (k == 0)
			k = 1;
		if (k > DEPTH)
			k = DEPTH;
		n = (held < k) ? held : k;
		v.label = '0;
		v.count = '0;
		for (int i = 0; i < n; i++) begin
			c = 0;
			for (int j = 0; j < n; j++)
				if (near_label[j] == near_label[i])
					c++;
			if (c > v.count || (c == v.count && near_label[i] < v.label)) begin
				v.count = count_t'(c);
				v.label = near_label[i];
			end
		end
		expected_votes.push_back(v);
		held = 0;
	endfunction

	function void check_vote(label_t label, count_t count);
		vote_t v;
		if (expected_votes.size() == 0) begin
			$display("%0t: unexpected vote transaction label %0d count %0d",
				$time, label, count);
			errors++;
			return;
		end
		v = expected_votes.pop_front();
		votes_checked++;
		if (label !== v.label) begin
			$display("%0t: winning_label expected %0d actual %0d", $time, v.label, label);
			errors++;
		end
		if (count !== v.count) begin
			$display("%0t: vote_count expected %0d actual %0d", $time, v.count, count);
			errors++;
		end
	endfunction

	function int pending();
		return expected_votes.size();
	endfunction
endclass

module tb_top;

	localparam int NEAREST_DEPTH  = 16;
	localparam int RANDOM_POINTS  = 1430;
	localparam int SETTLE_CYCLES  = 8;
	localparam int END_CYCLES     = 40;
	localparam int LONG_HOLD      = 400;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int LONG_HOLD_SET  = 30;
	localparam int CALM_FIRST     = 60;
	localparam int CALM_LAST      = 75;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            psel = 1'b0;
	logic                            penable = 1'b0;
	logic                            pwrite = 1'b0;
	logic [knnmc_pkg::ADDR_BITS-1:0] paddr = '0;
	logic [knnmc_pkg::DATA_BITS-1:0] pwdata = '0;
	logic [knnmc_pkg::DATA_BITS-1:0] prdata;
	logic                            pready;
	logic                            in_valid = 1'b0;
	logic                            in_ready;
	coord_t                          point_x = '0;
	coord_t                          point_y = '0;
	label_t                          point_label = '0;
	logic                            last_point = 1'b0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	label_t                          winning_label;
	count_t                          vote_count;

	knn_scoreboard #(NEAREST_DEPTH) sb;

	int points_sent = 0;
	int sets_sent = 0;
	int reg_writes = 0;
	int long_holds = 0;
	int stall_cycles = 0;
	bit long_hold_req = 1'b0;
	bit no_gaps = 1'b0;

	knn_majority_classifier_core #(
		.MAX_NEIGHBOURS(NEAREST_DEPTH)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.point_x      (point_x),
		.point_y      (point_y),
		.point_label  (point_label),
		.last_point   (last_point),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.winning_label(winning_label),
		.vote_count   (vote_count)
	);

	always #4 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic coord_t clamp_coord(int v);
		if (v > 32767)
			return 16'sh7FFF;
		if (v < -32768)
			return 16'sh8000;
		return coord_t'(v);
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_point(point_x, point_y, point_label, last_point);
			if (out_valid && out_ready)
				sb.check_vote(winning_label, vote_count);
		end
	end

	initial begin
		while (stall_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold = LONG_HOLD;
				long_holds++;
			end
			if (hold > 0) begin
				out_ready <= 1'b0;
				hold--;
			end else begin
				out_ready <= 1'b1;
				if (!no_gaps && $urandom_range(0, 99) < 30)
					hold = pick_gap();
			end
		end
	end

	task automatic send_point(coord_t x, coord_t y, label_t label, logic last);
		int gap;
		gap = no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		point_x     <= x;
		point_y     <= y;
		point_label <= label;
		last_point  <= last;
		do @(posedge clk); while (!in_ready);
		points_sent++;
		if (last)
			sets_sent++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_reg(logic [1:0] idx, logic [31:0] value);
		logic [31:0] mask;
		mask = (idx == knnmc_pkg::REG_NEIGHBOUR_COUNT) ? 32'h1F : 32'hFFFF;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		sb.write_reg(idx, value);
		reg_writes++;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if ((prdata & mask) !== (value & mask)) begin
			$display("%0t: register %0d readback expected %0h actual %0h",
				$time, idx, value & mask, prdata & mask);
			sb.errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_query(coord_t x, coord_t y);
		set_reg(knnmc_pkg::REG_QUERY_X, {{16{x[15]}}, x});
		set_reg(knnmc_pkg::REG_QUERY_Y, {{16{y[15]}}, y});
	endtask

	task automatic run_directed();
		// reset values: query at origin, k of one
		send_point(16'sd0, 16'sd0, 8'hFF, 1'b1);
		wait_idle();
		set_query(16'sh8000, 16'sh7FFF);
		set_reg(knnmc_pkg::REG_NEIGHBOUR_COUNT, 32'd16);
		// fewer points than k, opposite corners
		send_point(16'sh7FFF, 16'sh8000, 8'h00, 1'b0);
		send_point(16'sh8000, 16'sh7FFF, 8'hAA, 1'b0);
		send_point(16'sd0, 16'sd0, 8'hAA, 1'b1);
		wait_idle();
		set_query(16'sd0, 16'sd0);
		set_reg(knnmc_pkg::REG_NEIGHBOUR_COUNT, 32'd4);
		// vote tie goes to the smaller label
		send_point(16'sd256, 16'sd0, 8'd7, 1'b0);
		send_point(16'sd512, 16'sd0, 8'd3, 1'b0);
		send_point(-16'sd768, 16'sd0, 8'd7, 1'b0);
		send_point(16'sd0, 16'sd1024, 8'd3, 1'b1);
		wait_idle();
		set_reg(knnmc_pkg::REG_NEIGHBOUR_COUNT, 32'd1);
		// equal distance keeps the earlier point ahead
		send_point(16'sd0, 16'sd5, 8'd9, 1'b0);
		send_point(16'sd5, 16'sd0, 8'd4, 1'b1);
		wait_idle();
		set_reg(knnmc_pkg::REG_NEIGHBOUR_COUNT, 32'd0);
		send_point(16'sd1, 16'sd1, 8'h55, 1'b0);
		send_point(16'sd0, 16'sd0, 8'h12, 1'b1);
		wait_idle();
		set_reg(knnmc_pkg::REG_NEIGHBOUR_COUNT, 32'd31);
		send_point(16'sd3, -16'sd3, 8'd1, 1'b0);
		send_point(-16'sd2, 16'sd9, 8'd2, 1'b0);
		send_point(16'sd100, 16'sd100, 8'd2, 1'b1);
		wait_idle();
		set_reg(knnmc_pkg::REG_NEIGHBOUR_COUNT, 32'd1);
		// k changed in the middle of a set
		send_point(16'sd10, 16'sd0, 8'd6, 1'b0);
		send_point(16'sd20, 16'sd0, 8'd6, 1'b0);
		send_point(16'sd1, 16'sd0, 8'd8, 1'b0);
		wait_idle();
		set_reg(knnmc_pkg::REG_NEIGHBOUR_COUNT, 32'd3);
		send_point(16'sd30, 16'sd0, 8'd8, 1'b1);
		wait_idle();
	endtask

	function automatic coord_t pick_query_coord();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
		if (r < 30)
			return '0;
		if (r < 60)
			return clamp_coord($urandom_range(0, 4000) - 2000);
		return coord_t'($urandom_range(0, 65535));
	endfunction

	function automatic logic [31:0] pick_k();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 32'd0;
		if (r < 20)
			return $urandom_range(17, 31);
		if (r < 35)
			return 32'd16;
		if (r < 50)
			return 32'd1;
		return $urandom_range(2, 15);
	endfunction

	task automatic random_config();
		wait_idle();
		if ($urandom_range(0, 99) < 70)
			set_query(pick_query_coord(), pick_query_coord());
		if ($urandom_range(0, 99) < 70)
			set_reg(knnmc_pkg::REG_NEIGHBOUR_COUNT, pick_k());
	endtask

	function automatic coord_t pick_coord(coord_t centre);
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return coord_t'($urandom_range(0, 65535));
		if (r < 90)
			return clamp_coord(int'(centre) + $urandom_range(0, 1024) - 512);
		return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
	endfunction

	task automatic send_set(int len);
		label_t pool[4];
		int     pool_size;
		coord_t x;
		coord_t y;
		label_t label;
		pool_size = $urandom_range(1, 4);
		foreach (pool[i])
			pool[i] = label_t'($urandom_range(0, 255));
		x = '0;
		y = '0;
		for (int i = 0; i < len; i++) begin
			// reuse the previous coordinates now and then for equal distances
			if (i == 0 || $urandom_range(0, 99) >= 12) begin
				x = pick_coord(sb.query_x);
				y = pick_coord(sb.query_y);
			end
			if ($urandom_range(0, 99) < 80)
				label = pool[$urandom_range(0, pool_size - 1)];
			else
				label = label_t'($urandom_range(0, 255));
			send_point(x, y, label, i == len - 1);
		end
	endtask

	function automatic int pick_set_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 1;
		if (r < 60)
			return $urandom_range(2, 12);
		if (r < 90)
			return $urandom_range(13, 24);
		return $urandom_range(25, 48);
	endfunction

	task automatic run_random();
		int set_idx;
		set_idx = 0;
		while (points_sent < RANDOM_POINTS) begin
			no_gaps = (set_idx >= CALM_FIRST && set_idx < CALM_LAST);
			if (set_idx == LONG_HOLD_SET)
				long_hold_req = 1'b1;
			else if ((set_idx < LONG_HOLD_SET || set_idx > LONG_HOLD_SET + 5) &&
					$urandom_range(0, 99) < 15)
				random_config();
			send_set(pick_set_len());
			set_idx++;
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random();
		wait_idle();
		repeat (END_CYCLES) @(posedge clk);
		if (sb.pending() > 0) begin
			$display("%0t: %0d vote results never arrived", $time, sb.pending());
			sb.errors += sb.pending();
		end
		$display("Streamed %0d training points in %0d sets, checked %0d votes.",
			points_sent, sets_sent, sb.votes_checked);
		$display("Wrote %0d registers, held the result side off %0d time(s).",
			reg_writes, long_holds);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
